>>> rtl/core/tmit_pkg.sv
package tmit_pkg;

   localparam int MAC_W  = 48;
   localparam int TYPE_W = 3;

   // action codes
   localparam logic [1:0] ACT_LOOKUP = 2'd0;
   localparam logic [1:0] ACT_ADD    = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;
   localparam logic [1:0] ACT_READ   = 2'd3;

   // status codes
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_MISS   = 2'd1;
   localparam logic [1:0] STAT_FULL   = 2'd2;
   localparam logic [1:0] STAT_BADARG = 2'd3;

   localparam logic [TYPE_W-1:0] MIN_VALID_TYPE = 3'd1;
   localparam logic [TYPE_W-1:0] MAX_VALID_TYPE = 3'd6;

   typedef struct packed {
      logic [1:0]        action;
      logic [TYPE_W-1:0] threat_type;
      logic [MAC_W-1:0]  mac_address;
      logic [7:0]        entry_index;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [TYPE_W-1:0] found_type;
      logic [MAC_W-1:0]  found_mac;
      logic [4:0]        entry_total;
   } rsp_type;

   typedef struct packed {
      logic [TYPE_W-1:0] threat_type;
      logic [MAC_W-1:0]  mac_address;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SCAN,
      S_SHIFT,
      S_RESP
   } state_type;

endpackage

>>> rtl/core/typed_mac_ignore_table.sv
// channel  | ports                          | direction | item
// ---------+--------------------------------+-----------+------------------------------
// request  | req_valid req_ready req_data   | in        | action, type, mac, index
// response | rsp_valid rsp_ready rsp_data   | out       | status, type, mac, entry total
//
// one item at a time; the table sits in a single synchronous ram (one read, one write port)
// lookup and add walk the ram one entry a cycle until a hit or the end of the table
// remove copies each later entry down one slot; read fetches the indexed entry; a bad
// argument goes straight to the response state
// reset clears the state, entry count, pending flag and rsp_valid; ram needs no clearing
// a result waiting on rsp_ready does not block the next request, only its own response
module typed_mac_ignore_table
   import tmit_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // entry table
   entry_type mem [TABLE_DEPTH];

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;     // next entry to read
   logic [CNT_W-1:0] dst_ff, dst_in;       // shift destination
   logic             pend_ff, pend_in;     // read data valid this cycle
   rsp_type          res_ff, res_in;       // result waiting for the output slot
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   entry_type        rd_data_ff;

   logic [CNT_W-1:0] rd_addr;
   logic             wr_en;
   logic [CNT_W-1:0] wr_addr;
   entry_type        wr_data;

   logic             req_fire;
   logic             type_ok;
   logic             idx_ok;
   logic             scan_more;
   logic             scan_done;
   logic             hit;
   logic             table_full;
   logic             slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign type_ok    = (req_data.threat_type >= MIN_VALID_TYPE) &&
                       (req_data.threat_type <= MAX_VALID_TYPE);
   assign idx_ok     = 9'(req_data.entry_index) < 9'(count_ff);
   assign scan_more  = scan_ff < count_ff;
   assign scan_done  = !scan_more && !pend_ff;
   assign hit        = pend_ff && (rd_data_ff.threat_type == req_ff.threat_type) &&
                       (rd_data_ff.mac_address == req_ff.mac_address);
   assign table_full = (count_ff == CNT_W'(TABLE_DEPTH));
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_data.action) inside
                  ACT_LOOKUP, ACT_ADD: state_in = type_ok ? S_SCAN : S_RESP;
                  ACT_REMOVE:          state_in = idx_ok ? S_SHIFT : S_RESP;
                  ACT_READ:            state_in = idx_ok ? S_READ : S_RESP;
                  default:             state_in = S_RESP;
               endcase
            end
         end
         S_READ: state_in = S_RESP;
         S_SCAN: begin
            if (hit || scan_done) begin
               state_in = S_RESP;
            end
         end
         S_SHIFT: begin
            if (scan_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      req_in       = req_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      dst_in       = dst_ff;
      pend_in      = 1'b0;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_addr      = scan_ff;
      wr_en        = 1'b0;
      wr_addr      = dst_ff;
      wr_data      = rd_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = CNT_W'(req_data.entry_index);
            if (req_fire) begin
               req_in = req_data;
               res_in = '0;
               res_in.status = STAT_BADARG;
               scan_in = '0;
               dst_in  = CNT_W'(req_data.entry_index);
               if (req_data.action == ACT_REMOVE) begin
                  scan_in = CNT_W'(req_data.entry_index) + CNT_W'(1);
               end
            end
         end
         S_READ: begin
            res_in.status      = STAT_OK;
            res_in.found_type  = rd_data_ff.threat_type;
            res_in.found_mac   = rd_data_ff.mac_address;
         end
         S_SCAN: begin
            if (hit) begin
               res_in.status = STAT_OK;
            end else if (scan_done) begin
               if (req_ff.action == ACT_LOOKUP) begin
                  res_in.status = STAT_MISS;
               end else if (table_full) begin
                  res_in.status = STAT_FULL;
               end else begin
                  // append at the end of the packed table
                  wr_en   = 1'b1;
                  wr_addr = count_ff;
                  wr_data.threat_type = req_ff.threat_type;
                  wr_data.mac_address = req_ff.mac_address;
                  count_in = count_ff + CNT_W'(1);
                  res_in.status = STAT_OK;
               end
            end else begin
               pend_in = scan_more;
               if (scan_more) begin
                  scan_in = scan_ff + CNT_W'(1);
               end
            end
         end
         S_SHIFT: begin
            // entry read last cycle moves down one slot
            if (pend_ff) begin
               wr_en  = 1'b1;
               dst_in = dst_ff + CNT_W'(1);
            end
            pend_in = scan_more;
            if (scan_more) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            if (scan_done) begin
               count_in = count_ff - CNT_W'(1);
               res_in.status = STAT_OK;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               rsp_in             = res_ff;
               rsp_in.entry_total = 5'(9'(count_ff));
               rsp_valid_in       = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // table ram
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[IDX_W-1:0]] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      scan_ff <= scan_in;
      dst_ff  <= dst_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

endmodule

>>> rtl/core/tmit_checker.sv
module tmit_checker
   import tmit_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // entry data only on a successful read
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STAT_OK |->
         rsp_data.found_type == '0 && rsp_data.found_mac == '0)
      else $error("entry data on a failed action");

   // only valid types are ever stored
   a_found_type: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found_type != '0 |-> rsp_data.found_type <= MAX_VALID_TYPE)
      else $error("stored type out of range");

   // full means the count reached the depth
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STAT_FULL |->
         rsp_data.entry_total == 5'(TABLE_DEPTH))
      else $error("full reported below depth");

   // no response in the cycle after reset
   a_no_req_while_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response out of reset");

endmodule

bind typed_mac_ignore_table tmit_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_tmit_checker (.*);
